@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL of the UTF-8 width decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/u8w_pkg.sv @@
// Types, status codes and the width table of the UTF-8 width decoder.
`timescale 1ns / 1ps

package u8w_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [1:0]  char_width;
      logic [1:0]  status;
      logic [15:0] running_width;
      logic        last;
   } rsp_type;

   localparam logic [1:0] ST_CHAR     = 2'd0;
   localparam logic [1:0] ST_BAD_LEAD = 2'd1;
   localparam logic [1:0] ST_BAD_CONT = 2'd2;
   localparam logic [1:0] ST_DROPPED  = 2'd3;

   // Coarse terminal width: combining marks, jamo 1160-11F9 and FFFE-FFFF are 0; Hangul leads and CJK blocks are 2.
   function automatic logic [1:0] glyph_cols(input logic [20:0] c);
      logic [12:0] page;
      logic [1:0]  cols;
      page = c[20:8];
      cols = 2'd1;
      if (page <= 13'h002) begin
         cols = 2'd1;
      end else if (page == 13'h003) begin
         cols = (c >= 21'h000300 && c <= 21'h00036F) ? 2'd0 : 2'd1;
      end else if (page == 13'h011) begin
         if (c <= 21'h00115F) begin
            cols = 2'd2;
         end else if (c >= 21'h001160 && c <= 21'h0011F9) begin
            cols = 2'd0;
         end else begin
            cols = 2'd1;
         end
      end else if (page == 13'h020) begin
         cols = (c >= 21'h0020D0 && c <= 21'h0020EF) ? 2'd0 : 2'd1;
      end else if (page == 13'h0FE) begin
         cols = (c >= 21'h00FE20 && c <= 21'h00FE23) ? 2'd0 : 2'd1;
      end else if (page == 13'h0FF) begin
         cols = (c >= 21'h00FFFE) ? 2'd0 : 2'd1;
      end else if (page <= 13'h02D) begin
         cols = 2'd1;
      end else if (c >= 21'h002E80 && c <= 21'h003098) begin
         cols = 2'd2;
      end else if (c >= 21'h00309D && c <= 21'h004DB5) begin
         cols = 2'd2;
      end else if (c >= 21'h004E00 && c <= 21'h009FC3) begin
         cols = 2'd2;
      end else if (c >= 21'h00A000 && c <= 21'h00A4C6) begin
         cols = 2'd2;
      end
      return cols;
   endfunction

   // Running column count, held at its top value once it gets there.
   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {15'd0, b};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

endpackage

@@ rtl/core/utf8_decode_visual_width_core.sv @@
// Top level of the UTF-8 decoder that reports code points and terminal widths.
`timescale 1ns / 1ps
//
//   Channel  Ports                        Direction  Beat
//   req      req_valid req_stall req_data in         one buffer byte and end mark
//   rsp      rsp_valid rsp_stall rsp_data out        one character or error result
//
// A byte enters the input register and is decoded there once the queue has room.
// One byte per clock is sustained while the queue has room; a byte that yields two
// results writes both at once into a four-entry result queue, which gives one per pop.
// The input register stalls only while the queue lacks room for two results.
// Synchronous reset empties the queue and clears the decoder state.
// Results leave straight from the queue head, so rsp_stall has no combinational path to the decoder.

`include "assert_macros.svh"

module utf8_decode_visual_width_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  u8w_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output u8w_pkg::rsp_type  rsp_data
);
   import u8w_pkg::*;

   localparam int QDepth = 4;
   localparam int PtrW   = $clog2(QDepth);
   localparam int CntW   = $clog2(QDepth + 1);

   // Input register.
   logic         in_valid_ff;
   req_type      in_ff;

   // Decoder state.
   logic [20:0]  part_ff, part_in;
   logic [1:0]   due_ff, due_in;
   logic [15:0]  total_ff, total_in;

   // Result queue.
   rsp_type          q_ff [QDepth];
   logic [PtrW-1:0]  head_ff;
   logic [CntW-1:0]  count_ff, count_in;
   logic [PtrW-1:0]  wr0, wr1;

   logic         room, process, pop;
   logic [1:0]   n_res;
   rsp_type      res0, res1;

   // Lead byte decode.
   logic         lead_emit;
   logic [20:0]  lead_code;
   logic [1:0]   lead_cols, lead_st, lead_due;
   logic [20:0]  lead_part;
   logic [7:0]   b;
   logic [20:0]  cont_code;

   assign room      = count_ff <= CntW'(QDepth - 2);
   assign process   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = q_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;

   assign b         = in_ff.data_byte;
   assign cont_code = {part_ff[14:0], b[5:0]};

   always_comb begin
      lead_emit = 1'b0;
      lead_code = '0;
      lead_cols = 2'd1;
      lead_st   = ST_BAD_LEAD;
      lead_part = '0;
      lead_due  = 2'd0;
      if (!b[7]) begin
         lead_emit = 1'b1;
         lead_code = {13'd0, b};
         lead_cols = glyph_cols({13'd0, b});
         lead_st   = ST_CHAR;
      end else if (b[7:5] == 3'b110) begin
         lead_part = {16'd0, b[4:0]};
         lead_due  = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         lead_part = {17'd0, b[3:0]};
         lead_due  = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         lead_part = {18'd0, b[2:0]};
         lead_due  = 2'd3;
      end else begin
         lead_emit = 1'b1;
      end
   end

   always_comb begin
      res0    = '0;
      res1    = '0;
      n_res   = 2'd0;
      part_in = part_ff;
      due_in  = due_ff;
      if (due_ff == 2'd0) begin
         if (lead_emit) begin
            res0.code_point = lead_code;
            res0.char_width = lead_cols;
            res0.status     = lead_st;
            n_res           = 2'd1;
         end else begin
            part_in = lead_part;
            due_in  = lead_due;
         end
      end else if (b[7:6] == 2'b10) begin
         due_in = due_ff - 2'd1;
         if (due_ff == 2'd1) begin
            res0.code_point = cont_code;
            res0.char_width = glyph_cols(cont_code);
            res0.status     = ST_CHAR;
            n_res           = 2'd1;
            part_in         = '0;
         end else begin
            part_in = cont_code;
         end
      end else begin
         // The offending byte is reread as a lead byte after the error result.
         res0.char_width = 2'd1;
         res0.status     = ST_BAD_CONT;
         n_res           = 2'd1;
         part_in         = '0;
         due_in          = 2'd0;
         if (lead_emit) begin
            res1.code_point = lead_code;
            res1.char_width = lead_cols;
            res1.status     = lead_st;
            n_res           = 2'd2;
         end else begin
            part_in = lead_part;
            due_in  = lead_due;
         end
      end

      if (in_ff.end_of_buffer) begin
         if (n_res == 2'd0) begin
            res0.status = ST_DROPPED;
            n_res       = 2'd1;
         end
         if (n_res == 2'd2) begin
            res1.last = 1'b1;
         end else begin
            res0.last = 1'b1;
         end
         part_in = '0;
         due_in  = 2'd0;
      end

      res0.running_width = sat_add(total_ff, res0.char_width);
      res1.running_width = sat_add(res0.running_width, res1.char_width);

      if (in_ff.end_of_buffer) begin
         total_in = '0;
      end else if (n_res == 2'd2) begin
         total_in = res1.running_width;
      end else if (n_res == 2'd1) begin
         total_in = res0.running_width;
      end else begin
         total_in = total_ff;
      end
   end

   assign wr0      = head_ff + count_ff[PtrW-1:0];
   assign wr1      = wr0 + PtrW'(1);
   assign count_in = count_ff + (process ? CntW'(n_res) : CntW'(0)) - CntW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         part_ff     <= '0;
         due_ff      <= 2'd0;
         total_ff    <= '0;
         head_ff     <= '0;
         count_ff    <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (process) begin
            part_ff  <= part_in;
            due_ff   <= due_in;
            total_ff <= total_in;
         end
         if (pop) begin
            head_ff <= head_ff + PtrW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_ff <= req_data;
      end
      if (process && n_res != 2'd0) begin
         q_ff[wr0] <= res0;
      end
      if (process && n_res == 2'd2) begin
         q_ff[wr1] <= res1;
      end
   end

   `ASSERT_ALWAYS(a_queue_bound, clock, reset, count_ff <= CntW'(QDepth), "result queue overflow")
   `ASSERT_NEXT(a_end_clears, clock, reset, process && in_ff.end_of_buffer, due_ff == 2'd0 && total_ff == 16'd0 && part_ff == 21'd0, "decoder state not cleared after buffer end")
   `ASSERT_NEXT(a_end_result, clock, reset, process && in_ff.end_of_buffer, rsp_valid, "buffer end produced no result")
   `ASSERT_ALWAYS(a_stall_full, clock, reset, !req_stall || count_ff > CntW'(QDepth - 2), "input stalled with queue room")

endmodule
